@@ rtl/core/q4k_pkg.sv @@
// shared types, constants and helpers of the q4_k block dequantizer
`timescale 1ns / 1ps

package q4k_pkg;

   localparam logic [4:0] WORDS_PER_BLOCK = 5'd18;
   localparam logic [4:0] POS_SCALE_WORD0 = 5'd0;
   localparam logic [4:0] POS_SCALE_WORD1 = 5'd1;
   localparam logic [4:0] POS_FIRST_QUANT = 5'd2;
   localparam logic [3:0] LAST_RESULT     = 4'd15;
   localparam int         FIXED_WIDTH     = 41;
   localparam int         VALUE_WIDTH     = 51;

   // one quant word and everything the back end needs to expand it
   typedef struct packed {
      logic [63:0]                   quant_word;
      logic [1:0]                    group;
      logic [1:0]                    chunk;
      logic signed [FIXED_WIDTH-1:0] d_fixed;
      logic signed [FIXED_WIDTH-1:0] dm_fixed;
      logic [5:0]                    scale_lo;
      logic [5:0]                    min_lo;
      logic [5:0]                    scale_hi;
      logic [5:0]                    min_hi;
      logic                          not_finite;
   } q4k_entry_type;

   typedef struct packed {
      logic full;
      logic valid;
   } q4k_qstat_type;

   typedef struct packed {
      logic [5:0] scale;
      logic [5:0] minimum;
   } q4k_submin_type;

   function automatic logic q4k_half_bad(input logic [15:0] h);
      return h[14:10] == 5'h1f;
   endfunction

   // finite half in units of 2^-24
   function automatic logic signed [FIXED_WIDTH-1:0] q4k_half_fixed(input logic [15:0] h);
      logic [4:0]             e;
      logic [39:0]            mag;
      logic signed [FIXED_WIDTH-1:0] smag;
      e = h[14:10];
      if (e == 5'd0) begin
         mag = {30'd0, h[9:0]};
      end else begin
         mag = {29'd0, 1'b1, h[9:0]} << (e - 5'd1);
      end
      smag = $signed({1'b0, mag});
      return h[15] ? -smag : smag;
   endfunction

   function automatic logic [7:0] q4k_byte(input logic [95:0] s, input logic [3:0] idx);
      return s[{idx, 3'b000} +: 8];
   endfunction

   function automatic q4k_submin_type q4k_sub_scale_min(input logic [95:0] s,
                                                        input logic [2:0] i);
      q4k_submin_type r;
      logic [7:0]     b_lo;
      logic [7:0]     b_hi;
      logic [7:0]     b_up;
      b_lo = q4k_byte(s, {1'b0, i});
      b_hi = q4k_byte(s, {1'b0, i} + 4'd4);
      b_up = q4k_byte(s, {1'b0, i} - 4'd4);
      if (!i[2]) begin
         r.scale   = b_lo[5:0] & 6'h3f;
         r.minimum = b_hi[5:0] & 6'h3f;
      end else begin
         r.scale   = {b_up[7:6], b_hi[3:0] & 4'hf};
         r.minimum = {b_lo[7:6], b_hi[7:4]};
      end
      return r;
   endfunction

endpackage

@@ rtl/core/q4k_front.sv @@
// front end: tracks word position, keeps block scales, classifies words
`timescale 1ns / 1ps

module q4k_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [63:0]            block_word,
   input  logic                   block_start,
   output logic                   q_push,
   output q4k_pkg::q4k_entry_type q_entry
);

   logic [4:0]  word_position_ff, word_position_in;
   logic [15:0] super_scale_ff, super_scale_in;
   logic [15:0] super_minimum_ff, super_minimum_in;
   logic [95:0] packed_ff, packed_in;
   logic [4:0]  pos;
   logic [4:0]  quant_pos;
   logic        bad;
   q4k_pkg::q4k_submin_type sm_lo, sm_hi;

   assign pos       = block_start ? q4k_pkg::POS_SCALE_WORD0 : word_position_ff;
   assign quant_pos = pos - q4k_pkg::POS_FIRST_QUANT;
   assign bad       = q4k_pkg::q4k_half_bad(super_scale_ff) ||
                      q4k_pkg::q4k_half_bad(super_minimum_ff);
   assign sm_lo     = q4k_pkg::q4k_sub_scale_min(packed_ff, {quant_pos[3:2], 1'b0});
   assign sm_hi     = q4k_pkg::q4k_sub_scale_min(packed_ff, {quant_pos[3:2], 1'b1});

   always_comb begin
      word_position_in = word_position_ff;
      super_scale_in   = super_scale_ff;
      super_minimum_in = super_minimum_ff;
      packed_in        = packed_ff;
      q_push           = 1'b0;
      if (accept) begin
         if (pos >= q4k_pkg::WORDS_PER_BLOCK) begin
            word_position_in = q4k_pkg::WORDS_PER_BLOCK;
         end else begin
            word_position_in = pos + 5'd1;
            if (pos == q4k_pkg::POS_SCALE_WORD0) begin
               super_scale_in   = block_word[15:0];
               super_minimum_in = block_word[31:16];
               packed_in[31:0]  = block_word[63:32];
            end else if (pos == q4k_pkg::POS_SCALE_WORD1) begin
               packed_in[95:32] = block_word;
            end else begin
               q_push = 1'b1;
            end
         end
      end
   end

   always_comb begin
      q_entry.quant_word = block_word;
      q_entry.group      = quant_pos[3:2];
      q_entry.chunk      = quant_pos[1:0];
      q_entry.d_fixed    = bad ? '0 : q4k_pkg::q4k_half_fixed(super_scale_ff);
      q_entry.dm_fixed   = bad ? '0 : q4k_pkg::q4k_half_fixed(super_minimum_ff);
      q_entry.scale_lo   = sm_lo.scale;
      q_entry.min_lo     = sm_lo.minimum;
      q_entry.scale_hi   = sm_hi.scale;
      q_entry.min_hi     = sm_hi.minimum;
      q_entry.not_finite = bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_position_ff <= '0;
         super_scale_ff   <= '0;
         super_minimum_ff <= '0;
      end else begin
         word_position_ff <= word_position_in;
         super_scale_ff   <= super_scale_in;
         super_minimum_ff <= super_minimum_in;
      end
      packed_ff <= packed_in;
   end

endmodule

@@ rtl/core/q4k_queue.sv @@
// two-entry queue of classified quant words between front and back
`timescale 1ns / 1ps

module q4k_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  q4k_pkg::q4k_entry_type push_entry,
   input  logic                   pop,
   output q4k_pkg::q4k_entry_type head,
   output q4k_pkg::q4k_qstat_type status
);

   q4k_pkg::q4k_entry_type entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign head         = entries_ff[rd_ptr_ff];
   assign status.full  = count_ff == 2'd2;
   assign status.valid = count_ff != 2'd0;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/core/q4k_back.sv @@
// back end: expands one quant word into sixteen values over a three-stage pipe
`timescale 1ns / 1ps

module q4k_back (
   input  logic                   clock,
   input  logic                   reset,
   input  q4k_pkg::q4k_entry_type head,
   input  logic                   head_valid,
   output logic                   head_pop,
   input  logic                   out_pop,
   output logic                   out_valid,
   output logic [7:0]             out_index,
   output logic signed [q4k_pkg::VALUE_WIDTH-1:0] out_value,
   output logic                   out_not_finite,
   output logic                   out_last
);

   logic       advance;
   logic       issue;
   logic [3:0] cnt_ff, cnt_in;
   logic       half;
   logic [7:0] quant_byte;
   logic [3:0] nibble;
   logic [5:0] scale_sel;
   logic [5:0] min_sel;

   // stage 1
   logic                                  s1_v_ff;
   logic [7:0]                            s1_index_ff;
   logic [9:0]                            s1_sq_ff, s1_sq_in;
   logic [5:0]                            s1_mn_ff;
   logic signed [q4k_pkg::FIXED_WIDTH-1:0] s1_d_ff, s1_dm_ff;
   logic                                  s1_bad_ff, s1_last_ff;
   // stage 2
   logic                                  s2_v_ff;
   logic [7:0]                            s2_index_ff;
   logic signed [51:0]                    s2_a_ff, s2_a_in;
   logic signed [51:0]                    s2_b_ff, s2_b_in;
   logic signed [47:0]                    b_prod;
   logic                                  s2_bad_ff, s2_last_ff;
   // stage 3, the output word
   logic                                  s3_v_ff;
   logic [7:0]                            s3_index_ff;
   logic signed [51:0]                    diff;
   logic signed [q4k_pkg::VALUE_WIDTH-1:0] s3_value_ff;
   logic                                  s3_bad_ff, s3_last_ff;

   assign advance    = !s3_v_ff || out_pop;
   assign issue      = advance && head_valid;
   assign head_pop   = issue && (cnt_ff == q4k_pkg::LAST_RESULT);
   assign cnt_in     = issue ? cnt_ff + 4'd1 : cnt_ff;

   // low nibbles of all eight bytes first, then the high nibbles
   assign half       = cnt_ff[3];
   assign quant_byte = head.quant_word[{cnt_ff[2:0], 3'b000} +: 8];
   assign nibble     = half ? quant_byte[7:4] : quant_byte[3:0];
   assign scale_sel  = half ? head.scale_hi : head.scale_lo;
   assign min_sel    = half ? head.min_hi : head.min_lo;
   assign s1_sq_in   = {4'd0, scale_sel} * {6'd0, nibble};

   assign s2_a_in    = s1_d_ff * $signed({1'b0, s1_sq_ff});
   assign b_prod     = s1_dm_ff * $signed({1'b0, s1_mn_ff});
   assign s2_b_in    = {{4{b_prod[47]}}, b_prod};
   assign diff       = s2_a_ff - s2_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (advance) begin
            s1_v_ff <= issue;
            s2_v_ff <= s1_v_ff;
            s3_v_ff <= s2_v_ff;
         end
      end
      if (advance) begin
         s1_index_ff <= {head.group, half, head.chunk, cnt_ff[2:0]};
         s1_sq_ff    <= s1_sq_in;
         s1_mn_ff    <= min_sel;
         s1_d_ff     <= head.d_fixed;
         s1_dm_ff    <= head.dm_fixed;
         s1_bad_ff   <= head.not_finite;
         s1_last_ff  <= cnt_ff == q4k_pkg::LAST_RESULT;
         s2_index_ff <= s1_index_ff;
         s2_a_ff     <= s2_a_in;
         s2_b_ff     <= s2_b_in;
         s2_bad_ff   <= s1_bad_ff;
         s2_last_ff  <= s1_last_ff;
         s3_index_ff <= s2_index_ff;
         s3_value_ff <= diff[q4k_pkg::VALUE_WIDTH-1:0];
         s3_bad_ff   <= s2_bad_ff;
         s3_last_ff  <= s2_last_ff;
      end
   end

   assign out_valid      = s3_v_ff;
   assign out_index      = s3_index_ff;
   assign out_value      = s3_value_ff;
   assign out_not_finite = s3_bad_ff;
   assign out_last       = s3_last_ff;

endmodule

@@ rtl/core/q4k_block_dequantizer.sv @@
// top level of the q4_k super-block dequantizer
// the first value of a quant word goes via the queue entry, then pipe stages 1, 2 and 3
// a quant word gives sixteen values, one per cycle from the back-end pipe while the
// result port is empty or popped; scale words and excess words give no values
// a two-word queue lets up to two quant words wait while the back end drains
// reset clears word position, half scales, queue and pipe; scale bytes stay until written
`timescale 1ns / 1ps

module q4k_block_dequantizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [63:0] req_block_word,
   input  logic        req_block_start,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_element_index,
   output logic signed [50:0] rsp_value,
   output logic        rsp_scale_not_finite,
   output logic        rsp_last_in_run
);

   logic                   accept;
   logic                   q_push;
   logic                   q_pop;
   logic                   out_valid;
   q4k_pkg::q4k_entry_type q_entry;
   q4k_pkg::q4k_entry_type q_head;
   q4k_pkg::q4k_qstat_type q_status;

   assign req_full = q_status.full;
   assign accept   = req_push && !req_full;

   q4k_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .block_word  (req_block_word),
      .block_start (req_block_start),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   q4k_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   q4k_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (q_head),
      .head_valid     (q_status.valid),
      .head_pop       (q_pop),
      .out_pop        (rsp_pop),
      .out_valid      (out_valid),
      .out_index      (rsp_element_index),
      .out_value      (rsp_value),
      .out_not_finite (rsp_scale_not_finite),
      .out_last       (rsp_last_in_run)
   );

   assign rsp_empty = !out_valid;

   // the last word of a run is the high nibble of the eighth byte
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_last_in_run) |->
         (rsp_element_index[5] && (rsp_element_index[2:0] == 3'b111)))
      else $error("last_in_run on a word that is not the sixteenth");

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_scale_not_finite) |-> (rsp_value == '0))
      else $error("nonzero value with a non-finite scale");

   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_status.valid)
      else $error("queue popped while empty");

   assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("queue pushed while full");

endmodule

@@ dv/q4k_block_dequantizer_tb.sv @@
// self-checking testbench of the q4_k super-block dequantizer
`timescale 1ns / 1ps

module q4k_block_dequantizer_tb;

   localparam int DRAIN_CYCLES = 8;
   localparam int ITEM_TARGET  = 270;

   typedef struct {
      logic [7:0]                             index;
      logic signed [q4k_pkg::VALUE_WIDTH-1:0] value;
      logic                                   not_finite;
      logic                                   last;
   } dq_value_type;

   logic                                   clock           = 1'b0;
   logic                                   reset           = 1'b1;
   logic                                   req_push        = 1'b0;
   logic                                   req_full;
   logic [63:0]                            req_block_word  = '0;
   logic                                   req_block_start = 1'b0;
   logic                                   rsp_empty;
   logic                                   rsp_pop         = 1'b0;
   logic [7:0]                             rsp_element_index;
   logic signed [q4k_pkg::VALUE_WIDTH-1:0] rsp_value;
   logic                                   rsp_scale_not_finite;
   logic                                   rsp_last_in_run;

   dq_value_type pending_values[$];
   dq_value_type head;
   int           error_count   = 0;
   int           item_count    = 0;
   int           send_idle_pct = 8;
   int           pop_idle_pct  = 8;

   // predicted dequantizer state
   logic [4:0]  word_pos  = '0;
   logic [15:0] d_half    = '0;
   logic [15:0] dmin_half = '0;
   logic [7:0]  scale_bytes [12];

   q4k_block_dequantizer u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_block_word       (req_block_word),
      .req_block_start      (req_block_start),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_element_index    (rsp_element_index),
      .rsp_value            (rsp_value),
      .rsp_scale_not_finite (rsp_scale_not_finite),
      .rsp_last_in_run      (rsp_last_in_run)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // half value in units of 2^-24
   function automatic longint half_units(input logic [15:0] h);
      longint mag;
      if (h[14:10] == 5'd0) begin
         mag = {54'd0, h[9:0]};
      end else begin
         mag = {53'd0, 1'b1, h[9:0]};
         mag = mag << (int'(h[14:10]) - 1);
      end
      return h[15] ? -mag : mag;
   endfunction

   // {scale, minimum} of sub-block i from the twelve packed bytes
   function automatic logic [11:0] sub_pair(input int i);
      if (i < 4) begin
         return {scale_bytes[i][5:0], scale_bytes[i+4][5:0]};
      end
      return {scale_bytes[i-4][7:6], scale_bytes[i+4][3:0],
              scale_bytes[i][7:6], scale_bytes[i+4][7:4]};
   endfunction

   // updates the state for one word and queues its values; 0 when the word is ignored
   function automatic bit dequantize_word(input logic [63:0] w, input logic start);
      int           pos;
      int           grp;
      int           j0;
      int           n;
      int           q;
      int           sc;
      int           mn;
      logic         bad;
      longint       d;
      longint       dm;
      longint       v;
      logic [11:0]  pair [2];
      dq_value_type r;
      pos = start ? 0 : int'(word_pos);
      if (pos >= int'(q4k_pkg::WORDS_PER_BLOCK)) begin
         word_pos = q4k_pkg::WORDS_PER_BLOCK;
         return 1'b0;
      end
      word_pos = 5'(pos + 1);
      if (pos == int'(q4k_pkg::POS_SCALE_WORD0)) begin
         d_half    = w[15:0];
         dmin_half = w[31:16];
         for (int k = 0; k < 4; k++) scale_bytes[k] = w[32 + 8*k +: 8];
         return 1'b1;
      end
      if (pos == int'(q4k_pkg::POS_SCALE_WORD1)) begin
         for (int k = 0; k < 8; k++) scale_bytes[4 + k] = w[8*k +: 8];
         return 1'b1;
      end
      bad     = (d_half[14:10] == 5'h1f) || (dmin_half[14:10] == 5'h1f);
      d       = half_units(d_half);
      dm      = half_units(dmin_half);
      grp     = (pos - int'(q4k_pkg::POS_FIRST_QUANT)) >> 2;
      j0      = ((pos - int'(q4k_pkg::POS_FIRST_QUANT)) & 3) * 8;
      pair[0] = sub_pair(2 * grp);
      pair[1] = sub_pair(2 * grp + 1);
      n       = 0;
      // low nibbles of all eight bytes first, then the high nibbles
      for (int hi = 0; hi < 2; hi++) begin
         sc = pair[hi][11:6];
         mn = pair[hi][5:0];
         for (int k = 0; k < 8; k++) begin
            q = hi ? w[8*k + 4 +: 4] : w[8*k +: 4];
            v = d * sc * q - dm * mn;
            if (bad) v = 0;
            r.index      = 8'(64 * grp + 32 * hi + j0 + k);
            r.value      = v[q4k_pkg::VALUE_WIDTH-1:0];
            r.not_finite = bad;
            r.last       = (n == int'(q4k_pkg::LAST_RESULT));
            pending_values.insert(pending_values.size(), r);
            n++;
         end
      end
      return 1'b1;
   endfunction

   task automatic send_word(input logic [63:0] w, input logic start);
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_push        <= 1'b1;
      req_block_word  <= w;
      req_block_start <= start;
      do @(posedge clock); while (req_full);
      if (dequantize_word(w, start)) item_count++;
   endtask

   task automatic send_block(input logic [15:0] d, input logic [15:0] dmin,
                             input logic [95:0] scales, input int quant_words,
                             input logic first_start);
      send_word({scales[31:0], dmin, d}, first_start);
      send_word(scales[95:32], 1'b0);
      for (int n = 0; n < quant_words; n++) send_word({$urandom, $urandom}, 1'b0);
   endtask

   // hold off the sender until every expected word is back and the pipe is quiet
   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_values.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_scale_extremes();
      // first word after reset is word 0 even without a start mark
      send_block(16'h7bff, 16'hfbff, {96{1'b1}}, 0, 1'b0);
      send_word({64{1'b1}}, 1'b0);
      send_word(64'h0, 1'b0);
      send_word(64'h0123_4567_89ab_cdef, 1'b0);
      // subnormal scale, negative zero minimum, mixed upper scale bits
      send_block(16'h0001, 16'h8000, 96'hc0c0_3f3f_a5a5_5a5a_c33c_0ff0, 0, 1'b1);
      send_word(64'hfedc_ba98_7654_3210, 1'b0);
   endtask

   task automatic test_not_finite();
      send_block(16'h7c00, 16'h3c00, {$urandom, $urandom, $urandom}, 0, 1'b1);
      send_word({64{1'b1}}, 1'b0);
      send_block(16'h3c00, 16'hfe00, {$urandom, $urandom, $urandom}, 1, 1'b1);
   endtask

   task automatic test_start_mark();
      send_block(16'h3c00, 16'h3800, {$urandom, $urandom, $urandom}, 2, 1'b1);
      // restart in the middle of a block
      send_block(16'hc000, 16'h0400, {$urandom, $urandom, $urandom}, 1, 1'b1);
   endtask

   task automatic test_back_to_back();
      send_idle_pct = 0;
      pop_idle_pct  = 0;
      for (int b = 0; b < 2; b++) begin
         send_block(16'($urandom), 16'($urandom), {$urandom, $urandom, $urandom}, 16, 1'b1);
         // excess words past the end of the block
         send_word({$urandom, $urandom}, 1'b0);
         send_word({$urandom, $urandom}, 1'b0);
      end
      send_idle_pct = 8;
      pop_idle_pct  = 8;
   endtask

   task automatic test_random_blocks();
      int pick;
      bit paused;
      paused = 1'b0;
      while (item_count < ITEM_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            send_block(16'($urandom), 16'($urandom), {$urandom, $urandom, $urandom},
                       16, 1'b1);
            if ($urandom_range(4) == 0) begin
               repeat ($urandom_range(1, 3)) send_word({$urandom, $urandom}, 1'b0);
            end
         end else if (pick < 90) begin
            // cut short, the next block restarts it
            send_block(16'($urandom), 16'($urandom), {$urandom, $urandom, $urandom},
                       $urandom_range(0, 10), 1'b1);
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_word({$urandom, $urandom}, 1'($urandom_range(3) == 0));
            end
         end
         if (!paused && item_count > ITEM_TARGET / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_values.size() == 0) begin
            $error("unexpected word: element_index %0d value %0d",
                   rsp_element_index, rsp_value);
            error_count++;
         end else begin
            head = pending_values.pop_front();
            if (rsp_element_index !== head.index) begin
               $error("element_index: expected %0d, got %0d", head.index, rsp_element_index);
               error_count++;
            end
            if (rsp_value !== head.value) begin
               $error("value: expected %0d, got %0d", head.value, rsp_value);
               error_count++;
            end
            if (rsp_scale_not_finite !== head.not_finite) begin
               $error("scale_not_finite: expected %0b, got %0b",
                      head.not_finite, rsp_scale_not_finite);
               error_count++;
            end
            if (rsp_last_in_run !== head.last) begin
               $error("last_in_run: expected %0b, got %0b", head.last, rsp_last_in_run);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_scale_extremes();
      wait_drained();
      test_not_finite();
      wait_drained();
      test_start_mark();
      wait_drained();
      test_back_to_back();
      wait_drained();
      test_random_blocks();
      wait_drained();
      if (error_count == 0 && pending_values.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("Some tests failed");
      $finish;
   end

endmodule
